// ----- src/hcbd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types for the chunked body decoder
// Word formats, parse phase codes, status codes and the hex digit decoder.
// ----------------------------------------------------------------------------
package hcbd_pkg;

   // Parse phases of the chunked body grammar
   typedef enum logic [3:0] {
      PH_DIGITS   = 4'd0,
      PH_EXT      = 4'd1,
      PH_SIZE_LF  = 4'd2,
      PH_DATA     = 4'd3,
      PH_DATA_CR  = 4'd4,
      PH_DATA_LF  = 4'd5,
      PH_TRAIL    = 4'd6,
      PH_TRAIL_LF = 4'd7,
      PH_DONE     = 4'd8,
      PH_ERROR    = 4'd9
   } phase_type;

   // Body status codes
   typedef enum logic [1:0] {
      ST_BUSY  = 2'd0,
      ST_DONE  = 2'd1,
      ST_ERROR = 2'd2
   } status_type;

   localparam logic [7:0] CH_CR = 8'h0D;
   localparam logic [7:0] CH_LF = 8'h0A;

   // Input word
   typedef struct packed {
      logic [7:0] data_byte;
      logic       begin_body;
   } req_type;

   // Result word
   typedef struct packed {
      logic [7:0] body_byte;
      logic       body_valid;
      logic [1:0] status;
   } rsp_type;

   // Parser control state carried between bytes
   typedef struct packed {
      phase_type phase;
      logic      digit_seen;
      logic      line_empty;
   } ctl_type;

   // Hex digit decode: {is_digit, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c inside {[8'h41:8'h46]}) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c inside {[8'h61:8'h66]}) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

// ----- src/hcbd_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcbd_step: one-byte parse step
// Computes the next parser state and the result word for one input byte.
// ----------------------------------------------------------------------------
module hcbd_step import hcbd_pkg::*; #(
   parameter int SIZE_BITS = 32
) (
   input  req_type              req_word,
   input  ctl_type              ctl_cur,
   input  logic [SIZE_BITS-1:0] left_cur,
   output ctl_type              ctl_nxt,
   output logic [SIZE_BITS-1:0] left_nxt,
   output rsp_type              rsp_word
);

   ctl_type              ctl_eff;
   logic [SIZE_BITS-1:0] left_eff;
   logic [SIZE_BITS-1:0] left_dec;
   logic [4:0]           hex;
   logic [7:0]           c;

   assign c   = req_word.data_byte;
   assign hex = hex_decode(c);

   // Clear the parser ahead of the byte when a new body begins
   always_comb begin
      if (req_word.begin_body) begin
         ctl_eff.phase      = PH_DIGITS;
         ctl_eff.digit_seen = 1'b0;
         ctl_eff.line_empty = 1'b1;
         left_eff           = '0;
      end else begin
         ctl_eff  = ctl_cur;
         left_eff = left_cur;
      end
   end

   assign left_dec = left_eff - SIZE_BITS'(1);

   // Advance the grammar by one byte
   always_comb begin
      ctl_nxt             = ctl_eff;
      left_nxt            = left_eff;
      rsp_word.body_byte  = 8'h00;
      rsp_word.body_valid = 1'b0;
      case (ctl_eff.phase)
         PH_DIGITS: begin
            if (hex[4]) begin
               if (left_eff[SIZE_BITS-1 -: 4] != 4'h0) begin
                  ctl_nxt.phase = PH_ERROR;
               end else begin
                  left_nxt           = {left_eff[SIZE_BITS-5:0], hex[3:0]};
                  ctl_nxt.digit_seen = 1'b1;
               end
            end else if (!ctl_eff.digit_seen) begin
               ctl_nxt.phase = PH_ERROR;
            end else if (c == CH_CR) begin
               ctl_nxt.phase = PH_SIZE_LF;
            end else begin
               ctl_nxt.phase = PH_EXT;
            end
         end
         PH_EXT: begin
            if (c == CH_CR) begin
               ctl_nxt.phase = PH_SIZE_LF;
            end
         end
         PH_SIZE_LF: begin
            if (c != CH_LF) begin
               ctl_nxt.phase = PH_ERROR;
            end else if (left_eff == '0) begin
               ctl_nxt.phase      = PH_TRAIL;
               ctl_nxt.line_empty = 1'b1;
            end else begin
               ctl_nxt.phase = PH_DATA;
            end
         end
         PH_DATA: begin
            rsp_word.body_byte  = c;
            rsp_word.body_valid = 1'b1;
            left_nxt            = left_dec;
            if (left_dec == '0) begin
               ctl_nxt.phase = PH_DATA_CR;
            end
         end
         PH_DATA_CR: begin
            ctl_nxt.phase = (c == CH_CR) ? PH_DATA_LF : PH_ERROR;
         end
         PH_DATA_LF: begin
            if (c == CH_LF) begin
               ctl_nxt.phase      = PH_DIGITS;
               ctl_nxt.digit_seen = 1'b0;
               left_nxt           = '0;
            end else begin
               ctl_nxt.phase = PH_ERROR;
            end
         end
         PH_TRAIL: begin
            if (c == CH_CR) begin
               ctl_nxt.phase = PH_TRAIL_LF;
            end else begin
               ctl_nxt.line_empty = 1'b0;
            end
         end
         PH_TRAIL_LF: begin
            if (c != CH_LF) begin
               ctl_nxt.phase = PH_ERROR;
            end else if (ctl_eff.line_empty) begin
               ctl_nxt.phase = PH_DONE;
            end else begin
               ctl_nxt.line_empty = 1'b1;
               ctl_nxt.phase      = PH_TRAIL;
            end
         end
         PH_DONE: begin
            ctl_nxt.phase = PH_DONE;
         end
         default: begin
            ctl_nxt.phase = PH_ERROR;
         end
      endcase

      // Derive status from the phase left behind
      case (ctl_nxt.phase)
         PH_DONE:  rsp_word.status = ST_DONE;
         PH_ERROR: rsp_word.status = ST_ERROR;
         default:  rsp_word.status = ST_BUSY;
      endcase
   end

endmodule

// ----- src/http_chunked_body_decoder.sv -----
`timescale 1ns / 1ps
// Latency: a word accepted at one edge shows its result word from the next cycle.
// Throughput: one word per cycle while no result word waits under rsp_stall; the parse step is combinational.
// A new word enters in the cycle the held result word leaves; the input stalls
// while a result word waits under rsp_stall.
// Reset: synchronous; parse phase returns to size digits, size count clears,
// and the result register empties.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked transfer body decoder
// Parses size lines, passes chunk data through and tracks trailer lines.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder import hcbd_pkg::*; #(
   parameter int SIZE_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   ctl_type              ctl_ff;
   ctl_type              ctl_in;
   logic [SIZE_BITS-1:0] left_ff;
   logic [SIZE_BITS-1:0] left_in;
   rsp_type              rsp_ff;
   rsp_type              rsp_in;
   logic                 rsp_valid_ff;
   logic                 req_take;

   // Stall input only while a finished word sits blocked
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;

   hcbd_step #(
      .SIZE_BITS(SIZE_BITS)
   ) u_step (
      .req_word(req_data),
      .ctl_cur (ctl_ff),
      .left_cur(left_ff),
      .ctl_nxt (ctl_in),
      .left_nxt(left_in),
      .rsp_word(rsp_in)
   );

   // Parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff.phase      <= PH_DIGITS;
         ctl_ff.digit_seen <= 1'b0;
         ctl_ff.line_empty <= 1'b1;
         left_ff           <= '0;
      end else if (req_take) begin
         ctl_ff  <= ctl_in;
         left_ff <= left_in;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Checks
   a_take_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid_ff)
      else $error("accepted word produced no result");

   a_data_has_count: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.phase == PH_DATA |-> left_ff != '0)
      else $error("data phase with zero bytes left");

   a_payload_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.body_valid |-> rsp_ff.status == ST_BUSY)
      else $error("payload byte with final status");

   a_done_holds: assert property (@(posedge clock) disable iff (reset)
      ctl_ff.phase == PH_DONE && req_take && !req_data.begin_body
      |=> ctl_ff.phase == PH_DONE)
      else $error("completed body left done phase");

endmodule
